/* rtl/core/cascaded_interrupt_controller_macros.svh */
`ifndef CASCADED_INTERRUPT_CONTROLLER_MACROS_SVH
`define CASCADED_INTERRUPT_CONTROLLER_MACROS_SVH

// implication into the same cycle, checked on clk, off during reset
`define CIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cic check failed");

// implication into the following cycle
`define CIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cic check failed");

`endif

/* rtl/core/cic_pkg.sv */
`default_nettype none

package cic_pkg;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_RAISE = 3'd2;
  localparam logic [2:0] OP_LOWER = 3'd3;
  localparam logic [2:0] OP_ACK   = 3'd4;

  localparam logic [2:0] PORT_MASTER_CMD   = 3'd0;
  localparam logic [2:0] PORT_MASTER_DATA  = 3'd1;
  localparam logic [2:0] PORT_SLAVE_CMD    = 3'd2;
  localparam logic [2:0] PORT_SLAVE_DATA   = 3'd3;
  localparam logic [2:0] PORT_MASTER_LEVEL = 3'd4;
  localparam logic [2:0] PORT_SLAVE_LEVEL  = 3'd5;

  localparam logic [2:0] PH_ICW1  = 3'd0;
  localparam logic [2:0] PH_ICW2  = 3'd1;
  localparam logic [2:0] PH_ICW3  = 3'd2;
  localparam logic [2:0] PH_ICW4  = 3'd3;
  localparam logic [2:0] PH_READY = 3'd4;

  localparam logic [1:0] RSEL_REQUEST    = 2'd2;
  localparam logic [1:0] RSEL_IN_SERVICE = 2'd3;

  localparam logic [0:0] CFG_MASTER_LEVEL_MASK = 1'd0;
  localparam logic [0:0] CFG_SLAVE_LEVEL_MASK  = 1'd1;

  localparam logic [7:0] MASTER_LEVEL_MASK_RESET = 8'hf8;
  localparam logic [7:0] SLAVE_LEVEL_MASK_RESET  = 8'hde;

  localparam logic [3:0] CASCADE_LINE = 4'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] port_select;
    logic [2:0] access_bytes;
    logic [7:0] write_data;
    logic [3:0] line;
    logic [8:0] ack_vector;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       error;
    logic       int_pending;
    logic [8:0] next_vector;
    logic       vector_valid;
  } result_t;

  typedef struct packed {
    logic [7:0] request;
    logic [7:0] in_service;
    logic [7:0] mask;
    logic [7:0] level_trig;
    logic [7:0] init_word;
    logic [7:0] vector_base;
    logic [7:0] read_select;
    logic [2:0] init_phase;
  } chip_t;

  typedef struct packed {
    chip_t chip;
    logic  err;
  } chip_upd_t;

  localparam chip_t CHIP_RESET = '{
    request: 8'h00, in_service: 8'h00, mask: 8'h00, level_trig: 8'h00,
    init_word: 8'h00, vector_base: 8'h00, read_select: 8'h02,
    init_phase: PH_ICW1
  };

  function automatic chip_upd_t write_cmd(chip_t c, logic [7:0] cw, logic is_master);
    chip_upd_t u;
    u.chip = c;
    u.err  = 1'b0;
    if (cw[4]) begin
      u.chip.init_word  = cw;
      u.chip.init_phase = PH_ICW2;
    end else if (c.init_phase != PH_READY) begin
      u.err = 1'b1;
    end else if (cw[3]) begin
      u.chip.read_select = cw;
    end else if (cw[5] && !cw[7] && cw[6]) begin
      // specific eoi
      u.chip.in_service = c.in_service & ~(8'd1 << cw[2:0]);
    end else if (cw[5] && !cw[7] && !cw[6]) begin
      // non-specific eoi
      u.chip.in_service = c.in_service & (c.in_service - 8'd1);
    end else if (is_master && !cw[5] && cw[6]) begin
      u.chip = c;
    end else begin
      u.err = 1'b1;
    end
    return u;
  endfunction

  function automatic chip_upd_t write_data_port(chip_t c, logic [7:0] v);
    chip_upd_t u;
    u.chip = c;
    u.err  = 1'b0;
    unique case (c.init_phase)
      PH_ICW2: begin
        u.chip.vector_base = v;
        if (!c.init_word[1]) begin
          u.chip.init_phase = PH_ICW3;
        end else if (c.init_word[0]) begin
          u.chip.init_phase = PH_ICW4;
        end else begin
          u.chip.init_phase = PH_READY;
        end
      end
      PH_ICW3: begin
        u.chip.init_phase = c.init_word[0] ? PH_ICW4 : PH_READY;
      end
      PH_ICW4: begin
        u.chip.init_phase = PH_READY;
      end
      PH_ICW1, PH_READY: begin
        u.chip.mask = v;
      end
      default: begin
        u.err = 1'b1;
      end
    endcase
    return u;
  endfunction

  function automatic logic [7:0] read_cmd(chip_t c);
    logic [7:0] r;
    unique case (c.read_select[1:0])
      RSEL_REQUEST:    r = c.request;
      RSEL_IN_SERVICE: r = c.in_service;
      default:         r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic chip_t ack_chip(chip_t c, logic [7:0] bit_sel);
    chip_t n;
    n = c;
    if (|(c.request & ~c.mask & bit_sel)) begin
      n.in_service = c.in_service | bit_sel;
      if (!(|(c.level_trig & bit_sel))) begin
        n.request = c.request & ~bit_sel;
      end
    end
    return n;
  endfunction

  function automatic logic [2:0] lowest_set(logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic in_window(logic [8:0] vec, logic [7:0] base);
    logic [9:0] lo;
    logic [9:0] hi;
    lo = {2'b00, base};
    hi = lo + 10'd7;
    return ({1'b0, vec} >= lo) && ({1'b0, vec} <= hi);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cascaded_interrupt_controller.sv */
// Master/slave pair of fixed-priority interrupt controllers behind byte ports.
// Item channel (item_valid, item_stall, item): each transaction carries one
// operation: port read, port write, raise line, lower line or acknowledge.
// Result channel (result_valid, result_stall, result): exactly one result
// transaction per item, in order, with the read byte, an error flag and the
// pending flag and highest-priority pending vector seen after the operation.
// An item accepted at one edge has its result registered and valid from that
// edge on. Throughput is one item per cycle while no result waits on a stall;
// the whole operation and the priority encode sit between the item port and
// the result register.
// When the receiver stalls, the result register holds and item_stall is
// raised, so at most one result waits; as soon as the result is taken a new
// item is accepted in the same cycle.
// cfg_write/cfg_index/cfg_data load the two level mask registers; write them
// only while no transaction is in flight.
// Synchronous reset clears all chip state (read select back to the request
// register, both chips awaiting ICW1), loads the level masks with 0xf8 and
// 0xde, and empties the result register.
`default_nettype none

`include "cascaded_interrupt_controller_macros.svh"

module cascaded_interrupt_controller
  import cic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire item_t      item,
  output logic            result_valid,
  input  wire logic       result_stall,
  output result_t         result,
  input  wire logic       cfg_write,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  chip_t      master;
  chip_t      slave;
  chip_t      master_next;
  chip_t      slave_next;
  logic [7:0] master_level_mask;
  logic [7:0] slave_level_mask;
  result_t    result_next;
  logic       accept;

  chip_upd_t  upd;
  logic [7:0] rd;
  logic       err;
  logic [7:0] bit_sel;
  logic [7:0] mp;
  logic [7:0] sp;
  logic       state_pending;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    master_next = master;
    slave_next  = slave;
    rd          = 8'h00;
    err         = 1'b0;
    upd         = '{chip: master, err: 1'b0};
    bit_sel     = 8'd1 << item.ack_vector[2:0];
    unique case (item.op) inside
      OP_READ, OP_WRITE: begin
        if (item.access_bytes != 3'd1 || item.port_select > PORT_SLAVE_LEVEL) begin
          err = 1'b1;
        end else if (item.op == OP_READ) begin
          unique case (item.port_select)
            PORT_MASTER_CMD:   rd = read_cmd(master);
            PORT_MASTER_DATA:  rd = master.mask;
            PORT_SLAVE_CMD:    rd = read_cmd(slave);
            PORT_SLAVE_DATA:   rd = slave.mask;
            PORT_MASTER_LEVEL: rd = master.level_trig;
            default:           rd = slave.level_trig;
          endcase
        end else begin
          unique case (item.port_select)
            PORT_MASTER_CMD: begin
              upd         = write_cmd(master, item.write_data, 1'b1);
              master_next = upd.chip;
              err         = upd.err;
            end
            PORT_MASTER_DATA: begin
              upd         = write_data_port(master, item.write_data);
              master_next = upd.chip;
              err         = upd.err;
            end
            PORT_SLAVE_CMD: begin
              upd        = write_cmd(slave, item.write_data, 1'b0);
              slave_next = upd.chip;
              err        = upd.err;
            end
            PORT_SLAVE_DATA: begin
              upd        = write_data_port(slave, item.write_data);
              slave_next = upd.chip;
              err        = upd.err;
            end
            PORT_MASTER_LEVEL: begin
              master_next.level_trig = item.write_data & master_level_mask;
            end
            default: begin
              slave_next.level_trig = item.write_data & slave_level_mask;
            end
          endcase
        end
      end
      OP_RAISE: begin
        // line 2 is the cascade input, also flagged on slave line 1
        if (item.line == CASCADE_LINE) begin
          master_next.request = master.request | 8'h04;
          slave_next.request  = slave.request | 8'h02;
        end else if (!item.line[3]) begin
          master_next.request = master.request | (8'd1 << item.line[2:0]);
        end else begin
          slave_next.request = slave.request | (8'd1 << item.line[2:0]);
        end
      end
      OP_LOWER: begin
        if (!item.line[3]) begin
          master_next.request = master.request & ~(8'd1 << item.line[2:0]);
        end else begin
          slave_next.request = slave.request & ~(8'd1 << item.line[2:0]);
        end
      end
      OP_ACK: begin
        if (in_window(item.ack_vector, master.vector_base)) begin
          master_next = ack_chip(master, bit_sel);
        end else if (in_window(item.ack_vector, slave.vector_base)) begin
          slave_next = ack_chip(slave, bit_sel);
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    mp = master_next.request & ~master_next.mask;
    sp = slave_next.request & ~slave_next.mask;
    result_next.read_data    = rd;
    result_next.error        = err;
    result_next.int_pending  = (|mp) || (|sp);
    result_next.vector_valid = (|mp) || (|sp);
    if (|mp) begin
      result_next.next_vector = {1'b0, master_next.vector_base} + {6'd0, lowest_set(mp)};
    end else if (|sp) begin
      result_next.next_vector = {1'b0, slave_next.vector_base} + {6'd0, lowest_set(sp)};
    end else begin
      result_next.next_vector = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master            <= CHIP_RESET;
      slave             <= CHIP_RESET;
      master_level_mask <= MASTER_LEVEL_MASK_RESET;
      slave_level_mask  <= SLAVE_LEVEL_MASK_RESET;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_MASTER_LEVEL_MASK: master_level_mask <= cfg_data;
          CFG_SLAVE_LEVEL_MASK:  slave_level_mask  <= cfg_data;
          default:               master_level_mask <= master_level_mask;
        endcase
      end
      if (accept) begin
        master       <= master_next;
        slave        <= slave_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign state_pending = (|(master.request & ~master.mask)) ||
                         (|(slave.request & ~slave.mask));

  `CIC_ASSERT_NEXT(a_result_follows_accept, accept, result_valid)
  `CIC_ASSERT_NOW(a_pending_matches_state, result_valid, result.vector_valid == state_pending)
  `CIC_ASSERT_NOW(a_idle_vector_zero, result_valid && !result.vector_valid, result.next_vector == 9'd0)

endmodule

`default_nettype wire

/* tb/tb_cascaded_interrupt_controller.sv */
`default_nettype none

module tb_cascaded_interrupt_controller
  import cic_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] request;
    logic [7:0] in_service;
    logic [7:0] mask;
    logic [7:0] level_trig;
    logic [7:0] init_word;
    logic [7:0] vector_base;
    logic [7:0] read_select;
    logic [2:0] phase;
  } chip_model_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_write = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  chip_model_t pic [2];
  logic [7:0] master_lvl_mask;
  logic [7:0] slave_lvl_mask;
  logic [7:0] gen_base [2];

  item_t   pending_ops [$];
  result_t expected_responses [$];
  result_t want;
  int      fail_count = 0;
  int      gap_left;
  int      burst_left;
  int      stall_mode;
  int      mode_left;
  int      stall_tick;
  int      idle_cycles;

  cascaded_interrupt_controller uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t next_response(item_t it);
    result_t    r;
    logic [7:0] cw;
    logic [7:0] bitsel;
    logic [7:0] pend;
    logic       done;
    int         k;
    int         sel;
    int         i;
    r = '0;
    cw = it.write_data;
    k = int'(it.port_select[1]);
    case (it.op)
      OP_READ, OP_WRITE: begin
        if (it.access_bytes != 3'd1 || it.port_select > PORT_SLAVE_LEVEL) begin
          r.error = 1'b1;
        end else if (it.op == OP_READ) begin
          case (it.port_select)
            PORT_MASTER_CMD, PORT_SLAVE_CMD: begin
              if (pic[k].read_select[1:0] == RSEL_REQUEST) begin
                r.read_data = pic[k].request;
              end else if (pic[k].read_select[1:0] == RSEL_IN_SERVICE) begin
                r.read_data = pic[k].in_service;
              end
            end
            PORT_MASTER_DATA, PORT_SLAVE_DATA: r.read_data = pic[k].mask;
            PORT_MASTER_LEVEL: r.read_data = pic[0].level_trig;
            default: r.read_data = pic[1].level_trig;
          endcase
        end else begin
          case (it.port_select)
            PORT_MASTER_CMD, PORT_SLAVE_CMD: begin
              if (cw[4]) begin
                pic[k].init_word = cw;
                pic[k].phase = PH_ICW2;
              end else if (pic[k].phase != PH_READY) begin
                r.error = 1'b1;
              end else if (cw[3]) begin
                pic[k].read_select = cw;
              end else if (cw[5] && !cw[7] && cw[6]) begin
                pic[k].in_service[cw[2:0]] = 1'b0;
              end else if (cw[5] && !cw[7]) begin
                done = 1'b0;
                for (i = 0; i < 8; i++) begin
                  if (!done && pic[k].in_service[i]) begin
                    pic[k].in_service[i] = 1'b0;
                    done = 1'b1;
                  end
                end
              end else if (k == 0 && !cw[5] && cw[6]) begin
                // set-priority and no-op, master only
              end else begin
                r.error = 1'b1;
              end
            end
            PORT_MASTER_DATA, PORT_SLAVE_DATA: begin
              case (pic[k].phase)
                PH_ICW2: begin
                  pic[k].vector_base = cw;
                  if (!pic[k].init_word[1]) begin
                    pic[k].phase = PH_ICW3;
                  end else if (pic[k].init_word[0]) begin
                    pic[k].phase = PH_ICW4;
                  end else begin
                    pic[k].phase = PH_READY;
                  end
                end
                PH_ICW3: pic[k].phase = pic[k].init_word[0] ? PH_ICW4 : PH_READY;
                PH_ICW4: pic[k].phase = PH_READY;
                PH_ICW1, PH_READY: pic[k].mask = cw;
                default: r.error = 1'b1;
              endcase
            end
            PORT_MASTER_LEVEL: pic[0].level_trig = cw & master_lvl_mask;
            default: pic[1].level_trig = cw & slave_lvl_mask;
          endcase
        end
      end
      OP_RAISE: begin
        if (it.line == CASCADE_LINE) begin
          pic[0].request[CASCADE_LINE[2:0]] = 1'b1;
          // cascade also feeds slave input 1
          pic[1].request[1] = 1'b1;
        end else begin
          pic[it.line[3]].request[it.line[2:0]] = 1'b1;
        end
      end
      OP_LOWER: pic[it.line[3]].request[it.line[2:0]] = 1'b0;
      OP_ACK: begin
        if (int'(it.ack_vector) >= int'(pic[0].vector_base) &&
            int'(it.ack_vector) <= int'(pic[0].vector_base) + 7) begin
          sel = 0;
        end else if (int'(it.ack_vector) >= int'(pic[1].vector_base) &&
                     int'(it.ack_vector) <= int'(pic[1].vector_base) + 7) begin
          sel = 1;
        end else begin
          sel = -1;
        end
        if (sel < 0) begin
          r.error = 1'b1;
        end else begin
          bitsel = 8'd1 << it.ack_vector[2:0];
          if ((pic[sel].request & ~pic[sel].mask & bitsel) != 8'h00) begin
            pic[sel].in_service = pic[sel].in_service | bitsel;
            if ((pic[sel].level_trig & bitsel) == 8'h00) begin
              pic[sel].request = pic[sel].request & ~bitsel;
            end
          end
        end
      end
      default: r.error = 1'b1;
    endcase
    for (i = 0; i < 16; i++) begin
      pend = pic[i / 8].request & ~pic[i / 8].mask;
      if (!r.vector_valid && pend[i % 8]) begin
        r.vector_valid = 1'b1;
        r.next_vector = 9'(i % 8 + int'(pic[i / 8].vector_base));
      end
    end
    r.int_pending = r.vector_valid;
    return r;
  endfunction

  // sender: bursts of random length, random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_responses.push_back(next_response(item));
      end
      if (item_valid && item_stall) begin
        // hold the stalled transaction
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        item <= pending_ops.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 9) < 7);
        default: result_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_responses.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        want = expected_responses.pop_front();
        if (result.read_data !== want.read_data) begin
          $error("read_data expected %0h got %0h", want.read_data, result.read_data);
          fail_count++;
        end
        if (result.error !== want.error) begin
          $error("error expected %0b got %0b", want.error, result.error);
          fail_count++;
        end
        if (result.int_pending !== want.int_pending) begin
          $error("int_pending expected %0b got %0b", want.int_pending, result.int_pending);
          fail_count++;
        end
        if (result.next_vector !== want.next_vector) begin
          $error("next_vector expected %0h got %0h", want.next_vector, result.next_vector);
          fail_count++;
        end
        if (result.vector_valid !== want.vector_valid) begin
          $error("vector_valid expected %0b got %0b", want.vector_valid,
                 result.vector_valid);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("cascaded_interrupt_controller verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_item(input logic [2:0] op, input logic [2:0] port,
                            input logic [2:0] size, input logic [7:0] data,
                            input logic [3:0] ln, input logic [8:0] vec);
    item_t t;
    t.op = op;
    t.port_select = port;
    t.access_bytes = size;
    t.write_data = data;
    t.line = ln;
    t.ack_vector = vec;
    pending_ops.push_back(t);
  endtask

  task automatic port_access(input logic [2:0] op, input logic [2:0] port,
                             input logic [7:0] data);
    queue_item(op, port, 3'd1, data, 4'($urandom), 9'($urandom));
  endtask

  task automatic line_event(input logic [2:0] op, input logic [3:0] ln);
    queue_item(op, 3'($urandom), 3'($urandom), 8'($urandom), ln, 9'($urandom));
  endtask

  task automatic acknowledge(input logic [8:0] vec);
    queue_item(OP_ACK, 3'($urandom), 3'($urandom), 8'($urandom), 4'($urandom), vec);
  endtask

  task automatic init_chip(input int k);
    logic [7:0] icw1;
    logic [7:0] base;
    logic [2:0] cmd_port;
    logic [2:0] data_port;
    cmd_port = k ? PORT_SLAVE_CMD : PORT_MASTER_CMD;
    data_port = k ? PORT_SLAVE_DATA : PORT_MASTER_DATA;
    icw1 = 8'($urandom) | 8'h10;
    case ($urandom_range(0, 7))
      0: base = 8'h00;
      1: base = 8'hff;
      2: base = 8'hf8;
      default: base = 8'($urandom);
    endcase
    port_access(OP_WRITE, cmd_port, icw1);
    port_access(OP_WRITE, data_port, base);
    if (!icw1[1]) port_access(OP_WRITE, data_port, 8'($urandom));
    if (icw1[0]) port_access(OP_WRITE, data_port, 8'($urandom));
    port_access(OP_WRITE, data_port, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
    gen_base[k] = base;
  endtask

  task automatic interrupt_cycle();
    logic [3:0] ln;
    logic [2:0] cmd_port;
    ln = 4'($urandom);
    cmd_port = ln[3] ? PORT_SLAVE_CMD : PORT_MASTER_CMD;
    line_event(OP_RAISE, ln);
    if ($urandom_range(0, 1)) port_access(OP_READ, cmd_port, 8'($urandom));
    acknowledge(9'(gen_base[ln[3]]) + 9'(ln[2:0]));
    if ($urandom_range(0, 1)) port_access(OP_READ, cmd_port, 8'($urandom));
    case ($urandom_range(0, 2))
      0: port_access(OP_WRITE, cmd_port, {5'b01100, ln[2:0]});
      1: port_access(OP_WRITE, cmd_port, 8'h20);
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) line_event(OP_LOWER, ln);
  endtask

  task automatic random_ops(input int count);
    int pick;
    logic [2:0] cmd_port;
    logic [2:0] data_port;
    while (pending_ops.size() < count) begin
      pick = $urandom_range(0, 99);
      cmd_port = $urandom_range(0, 1) ? PORT_SLAVE_CMD : PORT_MASTER_CMD;
      data_port = $urandom_range(0, 1) ? PORT_SLAVE_DATA : PORT_MASTER_DATA;
      if (pick < 10) begin
        init_chip($urandom_range(0, 1));
      end else if (pick < 55) begin
        interrupt_cycle();
      end else if (pick < 62) begin
        port_access(OP_WRITE, cmd_port,
                    {3'($urandom), 2'b01, 3'($urandom)});
        port_access(OP_READ, cmd_port, 8'($urandom));
      end else if (pick < 69) begin
        port_access(OP_WRITE, cmd_port, {3'($urandom), 2'b00, 3'($urandom)});
      end else if (pick < 76) begin
        port_access(OP_WRITE, $urandom_range(0, 1) ? PORT_SLAVE_LEVEL : PORT_MASTER_LEVEL,
                    8'($urandom));
      end else if (pick < 84) begin
        port_access(OP_READ, 3'($urandom_range(0, 5)), 8'($urandom));
      end else if (pick < 90) begin
        port_access(OP_WRITE, data_port,
                    ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom) & 8'($urandom));
      end else if (pick < 94) begin
        acknowledge(9'($urandom));
      end else begin
        queue_item(3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom),
                   4'($urandom), 9'($urandom));
      end
    end
  endtask

  task automatic wait_quiet();
    do begin
      @(negedge clk);
    end while (pending_ops.size() != 0 || item_valid || expected_responses.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_level_masks(input logic [7:0] m, input logic [7:0] s);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MASTER_LEVEL_MASK;
    cfg_data <= m;
    @(posedge clk);
    cfg_index <= CFG_SLAVE_LEVEL_MASK;
    cfg_data <= s;
    @(posedge clk);
    cfg_write <= 1'b0;
    master_lvl_mask = m;
    slave_lvl_mask = s;
  endtask

  initial begin
    for (int k = 0; k < 2; k++) begin
      pic[k] = '0;
      pic[k].read_select = 8'h02;
      pic[k].phase = PH_ICW1;
    end
    master_lvl_mask = MASTER_LEVEL_MASK_RESET;
    slave_lvl_mask = SLAVE_LEVEL_MASK_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: init paths, cascade, acks, eoi variants, bad accesses
    port_access(OP_READ, PORT_MASTER_CMD, 8'h00);
    port_access(OP_WRITE, PORT_MASTER_DATA, 8'h00);
    port_access(OP_WRITE, PORT_MASTER_CMD, 8'h20);
    port_access(OP_WRITE, PORT_MASTER_CMD, 8'h11);
    port_access(OP_WRITE, PORT_MASTER_DATA, 8'h20);
    port_access(OP_WRITE, PORT_MASTER_DATA, 8'h04);
    port_access(OP_WRITE, PORT_MASTER_DATA, 8'h01);
    port_access(OP_WRITE, PORT_SLAVE_CMD, 8'h12);
    port_access(OP_WRITE, PORT_SLAVE_DATA, 8'hf8);
    port_access(OP_WRITE, PORT_SLAVE_DATA, 8'h00);
    gen_base[0] = 8'h20;
    gen_base[1] = 8'hf8;
    line_event(OP_RAISE, CASCADE_LINE);
    line_event(OP_RAISE, 4'd15);
    line_event(OP_RAISE, 4'd0);
    acknowledge(9'h020);
    acknowledge(9'h0ff);
    acknowledge(9'h1ff);
    port_access(OP_WRITE, PORT_MASTER_CMD, 8'h0b);
    port_access(OP_READ, PORT_MASTER_CMD, 8'h00);
    port_access(OP_WRITE, PORT_MASTER_CMD, 8'h60);
    port_access(OP_WRITE, PORT_SLAVE_CMD, 8'h20);
    port_access(OP_WRITE, PORT_MASTER_CMD, 8'hc0);
    port_access(OP_WRITE, PORT_SLAVE_CMD, 8'h40);
    port_access(OP_WRITE, PORT_SLAVE_LEVEL, 8'hff);
    port_access(OP_READ, PORT_SLAVE_LEVEL, 8'h00);
    queue_item(OP_READ, PORT_MASTER_CMD, 3'd0, 8'h00, 4'd0, 9'd0);
    queue_item(OP_WRITE, 3'd7, 3'd4, 8'hff, 4'd0, 9'd0);
    queue_item(OP_READ, 3'd6, 3'd1, 8'h00, 4'd0, 9'd0);
    queue_item(3'd7, PORT_MASTER_CMD, 3'd1, 8'h00, 4'd0, 9'd0);
    line_event(OP_LOWER, CASCADE_LINE);
    line_event(OP_LOWER, 4'd9);
    wait_quiet();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: set_level_masks(8'hff, 8'hff);
        2: set_level_masks(8'h00, 8'h00);
        default: set_level_masks(8'($urandom), 8'($urandom));
      endcase
      init_chip(0);
      init_chip(1);
      random_ops(200);
      wait_quiet();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0 && expected_responses.size() == 0) begin
      $display("cascaded_interrupt_controller verification clean");
    end else begin
      $display("cascaded_interrupt_controller verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
